// ===== rtl/apfc_pkg.sv =====
// shared types and constants of the access panel frame checker
`default_nettype none

package apfc_pkg;

    // frame size limit default
    localparam int MAX_FRAME_DEFAULT = 512;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // fixed header bytes
    localparam logic [7:0] MARK_BYTE  = 8'hFF;
    localparam logic [7:0] START_BYTE = 8'h53;

    // control byte fields
    localparam logic [7:0] SEQ_MASK = 8'h03;
    localparam logic [7:0] CRC_FLAG = 8'h04;

    // crc-16 setup
    localparam logic [15:0] CRC_INIT = 16'h1D0F;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // sequence counter value after reset (minus one, reads as 3)
    localparam logic [2:0] SEQ_RESET_VALUE = 3'd7;

    // header byte positions
    localparam int HDR_MARK    = 0;
    localparam int HDR_START   = 1;
    localparam int HDR_ADDRESS = 2;
    localparam int HDR_LEN_LO  = 3;
    localparam int HDR_LEN_HI  = 4;
    localparam int HDR_CTRL    = 5;
    localparam int PAYLOAD_POS = 6;

    // configuration register indexes
    localparam logic [0:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [0:0] CFG_SKIP_SEQ_CHECK = 1'b1;

    // input command codes
    typedef enum logic [1:0] {
        CMD_BYTE      = 2'd0,
        CMD_ADVANCE   = 2'd1,
        CMD_SEQ_RESET = 2'd2
    } cmd_t;

    // operation kinds passed from front to back
    typedef enum logic [1:0] {
        OP_BYTE      = 2'd0,
        OP_ADVANCE   = 2'd1,
        OP_SEQ_RESET = 2'd2
    } op_kind_t;

    // frame status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MARK     = 3'd1,
        ST_START    = 3'd2,
        ST_ADDRESS  = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_SEQUENCE = 3'd5,
        ST_CRC      = 3'd6,
        ST_CHECKSUM = 3'd7
    } status_t;

    // one classified operation
    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
        logic       last;
        logic       counted;
    } op_t;

    // configuration register set
    typedef struct packed {
        logic [7:0] device_address;
        logic       skip_seq_check;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/access_panel_frame_checker.sv =====
// top level of the access panel frame checker
`default_nettype none

// Checks a received access panel frame one byte per beat: mark 0xFF, start
// 0x53, device address, 16-bit length (low byte first) against the byte
// count minus one, and the two-bit sequence number unless skip_seq_check is
// set; the trailer is a CRC-16 (0x1021, init 0x1D0F) when control bit 0x04
// is set, else a two's-complement checksum. Message block bytes come out as
// payload beats while the frame streams in, and the last byte gives one
// status beat with the payload length. Commands 1 and 2 advance or reset the
// sequence counter (reads 3 after reset). The block takes one input beat per
// clock cycle while the queue has room; an accepted beat passes through the
// two-entry queue between the decoding front end and the checking back end
// and then through the output register. The back end updates the CRC by a
// whole byte in each cycle that it takes one, which sets the clock rate.
// Frames longer than MAX_FRAME bytes end in a length error.
module access_panel_frame_checker #(
    parameter int MAX_FRAME = apfc_pkg::MAX_FRAME_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // received beats
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        last_byte,
    // result beats
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             is_status,
    output logic [7:0]       payload_byte,
    output logic [2:0]       status,
    output logic [9:0]       payload_length
);
    import apfc_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAME + 1);
    localparam int Q_W   = $bits(op_t) + IDX_W;

    cfg_t             cfg_reg;
    logic             push_valid;
    logic             push_ready;
    op_t              push_op;
    logic [IDX_W-1:0] push_idx;
    logic             q_valid;
    logic             q_ready;
    logic [Q_W-1:0]   q_data;
    op_t              q_op;
    logic [IDX_W-1:0] q_idx;
    status_t          back_status;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data;
                CFG_SKIP_SEQ_CHECK: cfg_reg.skip_seq_check <= cfg_data[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end
    apfc_front #(
        .MAX_FRAME (MAX_FRAME),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .rx_byte    (rx_byte),
        .last_byte  (last_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .push_idx   (push_idx)
    );

    // queue between front and back
    apfc_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_op, push_idx}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign {q_op, q_idx} = q_data;

    // back end
    apfc_back #(
        .MAX_FRAME (MAX_FRAME),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_op           (q_op),
        .q_idx          (q_idx),
        .cfg            (cfg_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .is_status      (is_status),
        .payload_byte   (payload_byte),
        .status         (back_status),
        .payload_length (payload_length)
    );

    assign status = back_status;

    // a payload beat carries no status and no length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> back_status == ST_OK && payload_length == '0)
        else $error("payload beat with status fields set");

    // a failed frame reports no payload length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status && back_status != ST_OK |-> payload_length == '0)
        else $error("failed frame with nonzero payload length");

    // the byte position restarts after the last byte of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_BYTE && last_byte |=> push_idx == '0)
        else $error("byte position not cleared after last byte");

    // a stalled result beat holds its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({is_status, payload_byte, back_status, payload_length}))
        else $error("result beat changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/apfc_front.sv =====
// front end: command decode and frame byte position counter
`default_nettype none

module apfc_front #(
    parameter int MAX_FRAME = 512,
    parameter int IDX_W     = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              last_byte,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output apfc_pkg::op_t          push_op,
    output logic [IDX_W-1:0]       push_idx
);
    import apfc_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             cmd_known;
    logic             counted;
    logic             accept;

    // unused command codes are taken and dropped
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign counted  = (idx_reg != IDX_W'(MAX_FRAME));

    // classify the command
    always_comb
    begin
        cmd_known       = 1'b1;
        push_op.kind    = OP_BYTE;
        push_op.data    = rx_byte;
        push_op.last    = last_byte;
        push_op.counted = counted;
        unique case (cmd_t'(command))
            CMD_BYTE:      push_op.kind = OP_BYTE;
            CMD_ADVANCE:   push_op.kind = OP_ADVANCE;
            CMD_SEQ_RESET: push_op.kind = OP_SEQ_RESET;
            default:       cmd_known = 1'b0;
        endcase
    end

    assign push_idx        = idx_reg;
    assign push_valid      = in_valid && cmd_known;

    // byte position, saturating at the frame limit, cleared after the last byte
    always_comb
    begin
        idx_next = idx_reg;
        if (accept && cmd_t'(command) == CMD_BYTE)
        begin
            if (last_byte)
            begin
                idx_next = '0;
            end
            else if (counted)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/apfc_queue.sv =====
// small first-in first-out queue between front and back
`default_nettype none

module apfc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/apfc_back.sv =====
// back end: header checks, trailer accumulation, sequence counter, result register
`default_nettype none

module apfc_back #(
    parameter int MAX_FRAME = 512,
    parameter int IDX_W     = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire apfc_pkg::op_t      q_op,
    input  wire logic [IDX_W-1:0]   q_idx,
    input  wire apfc_pkg::cfg_t     cfg,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    is_status,
    output logic [7:0]              payload_byte,
    output apfc_pkg::status_t       status,
    output logic [9:0]              payload_length
);
    import apfc_pkg::*;

    localparam int CMP_W = ((IDX_W > 16) ? IDX_W : 16) + 1;

    // frame state
    logic [2:0]  seq_reg;
    logic [2:0]  seq_next;
    status_t     first_error_reg;
    status_t     first_error_next;
    logic [15:0] declared_length_reg;
    logic [15:0] declared_length_next;
    logic        use_crc_reg;
    logic        use_crc_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [15:0] rx_check_reg;
    logic [15:0] rx_check_next;

    // result register
    logic        out_valid_reg;
    logic        is_status_reg;
    logic [7:0]  payload_byte_reg;
    status_t     status_reg;
    logic [9:0]  payload_length_reg;

    logic             fire;
    logic             emit;
    logic             emit_status;
    status_t          res_status;
    logic [9:0]       res_plen;
    logic [1:0]       trail;
    logic [CMP_W-1:0] idx_x;
    logic [CMP_W-1:0] len_x;
    logic             in_body;
    logic             past_header;
    logic [7:0]       b;

    // one crc-16 byte step, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    assign q_ready = !out_valid_reg || out_ready;
    assign fire    = q_valid && q_ready;
    assign b       = q_op.data;
    assign idx_x   = CMP_W'(q_idx);
    assign past_header = (q_idx >= IDX_W'(PAYLOAD_POS));

    // process the operation at the queue head
    always_comb
    begin
        seq_next             = seq_reg;
        first_error_next     = first_error_reg;
        declared_length_next = declared_length_reg;
        use_crc_next         = use_crc_reg;
        crc_next             = crc_reg;
        sum_next             = sum_reg;
        rx_check_next        = rx_check_reg;
        emit                 = 1'b0;
        emit_status          = 1'b0;
        res_status           = ST_OK;
        res_plen             = '0;
        trail                = 2'd1;
        len_x                = '0;
        in_body              = 1'b0;
        if (fire)
        begin
            case (q_op.kind)
                OP_ADVANCE:
                begin
                    if (seq_reg == SEQ_RESET_VALUE)
                    begin
                        seq_next = 3'd0;
                    end
                    else if (seq_reg < 3'd3)
                    begin
                        seq_next = seq_reg + 3'd1;
                    end
                    else
                    begin
                        seq_next = 3'd1;
                    end
                end
                OP_SEQ_RESET:
                begin
                    seq_next = SEQ_RESET_VALUE;
                end
                OP_BYTE:
                begin
                    // header field checks, first failure wins
                    if (q_idx == IDX_W'(HDR_MARK))
                    begin
                        if (b != MARK_BYTE && first_error_next == ST_OK)
                        begin
                            first_error_next = ST_MARK;
                        end
                    end
                    else if (q_idx == IDX_W'(HDR_START))
                    begin
                        if (b != START_BYTE && first_error_next == ST_OK)
                        begin
                            first_error_next = ST_START;
                        end
                    end
                    else if (q_idx == IDX_W'(HDR_ADDRESS))
                    begin
                        if (b != cfg.device_address && first_error_next == ST_OK)
                        begin
                            first_error_next = ST_ADDRESS;
                        end
                    end
                    else if (q_idx == IDX_W'(HDR_LEN_LO))
                    begin
                        declared_length_next = {8'h00, b};
                    end
                    else if (q_idx == IDX_W'(HDR_LEN_HI))
                    begin
                        declared_length_next = {b, declared_length_reg[7:0]};
                    end
                    else if (q_idx == IDX_W'(HDR_CTRL))
                    begin
                        use_crc_next = ((b & CRC_FLAG) != 8'h00);
                        if (!cfg.skip_seq_check
                            && (b & SEQ_MASK) != ({5'b0, seq_reg} & SEQ_MASK)
                            && first_error_next == ST_OK)
                        begin
                            first_error_next = ST_SEQUENCE;
                        end
                    end

                    trail   = use_crc_next ? 2'd2 : 2'd1;
                    len_x   = CMP_W'(declared_length_next);
                    in_body = (idx_x + CMP_W'(trail)) <= len_x;

                    // trailer accumulation over the header bytes after the mark and the message block
                    if (q_op.counted && q_idx != IDX_W'(HDR_MARK)
                        && (q_idx <= IDX_W'(HDR_CTRL) || in_body))
                    begin
                        crc_next = crc_byte(crc_reg, b);
                        sum_next = sum_reg + b;
                    end
                    if (q_op.counted && past_header)
                    begin
                        rx_check_next = {b, rx_check_reg[15:8]};
                    end

                    if (!q_op.last)
                    begin
                        emit = q_op.counted && past_header && in_body;
                    end
                    else
                    begin
                        // final status of the frame
                        emit        = 1'b1;
                        emit_status = 1'b1;
                        if (first_error_next == ST_MARK || first_error_next == ST_START
                            || first_error_next == ST_ADDRESS)
                        begin
                            res_status = first_error_next;
                        end
                        else if (idx_x < CMP_W'(HDR_CTRL)
                                 || len_x < CMP_W'(PAYLOAD_POS) + CMP_W'(trail)
                                 || len_x > CMP_W'(MAX_FRAME - 1)
                                 || idx_x != len_x)
                        begin
                            res_status = ST_LENGTH;
                        end
                        else if (first_error_next != ST_OK)
                        begin
                            res_status = first_error_next;
                        end
                        else if (use_crc_next)
                        begin
                            if (crc_next != rx_check_next)
                            begin
                                res_status = ST_CRC;
                            end
                        end
                        else
                        begin
                            if ((8'h00 - sum_next) != rx_check_next[15:8])
                            begin
                                res_status = ST_CHECKSUM;
                            end
                        end
                        if (res_status == ST_OK)
                        begin
                            res_plen = 10'(declared_length_next - 16'd5 - 16'(trail));
                        end

                        // frame state back to its idle values
                        first_error_next     = ST_OK;
                        declared_length_next = '0;
                        use_crc_next         = 1'b0;
                        crc_next             = CRC_INIT;
                        sum_next             = '0;
                        rx_check_next        = '0;
                    end
                end
                default:
                begin
                    seq_next = seq_reg;
                end
            endcase
        end
    end

    // frame and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg             <= SEQ_RESET_VALUE;
            first_error_reg     <= ST_OK;
            declared_length_reg <= '0;
            use_crc_reg         <= 1'b0;
            crc_reg             <= CRC_INIT;
            sum_reg             <= '0;
            rx_check_reg        <= '0;
        end
        else
        begin
            seq_reg             <= seq_next;
            first_error_reg     <= first_error_next;
            declared_length_reg <= declared_length_next;
            use_crc_reg         <= use_crc_next;
            crc_reg             <= crc_next;
            sum_reg             <= sum_next;
            rx_check_reg        <= rx_check_next;
        end
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            is_status_reg      <= emit_status;
            payload_byte_reg   <= emit_status ? 8'h00 : b;
            status_reg         <= res_status;
            payload_length_reg <= res_plen;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_status      = is_status_reg;
    assign payload_byte   = payload_byte_reg;
    assign status         = status_reg;
    assign payload_length = payload_length_reg;

endmodule

`default_nettype wire

// ===== tb/apfc_result_checker.sv =====
// result checker for the access panel frame checker: mirrors the frame checks and compares beats
module apfc_result_checker #(
    parameter int MAX_FRAME = apfc_pkg::MAX_FRAME_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] rx_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       is_status,
    input  logic [7:0] payload_byte,
    input  logic [2:0] status,
    input  logic [9:0] payload_length,
    output int         mismatch_count,
    output int         pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import apfc_pkg::*;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        status_t    status;
        logic [9:0] payload_length;
    } frame_result_t;

    frame_result_t expected_results[$];

    // register copies
    logic [7:0] own_address;
    logic       skip_seq;

    // sequence counter and per-frame state
    logic [2:0]  seq_count;
    int          byte_pos;
    status_t     first_fault;
    logic [15:0] length_field;
    logic [7:0]  ctrl_byte;
    logic [15:0] crc_run;
    logic [7:0]  sum_run;
    logic [15:0] check_bytes;

    // one byte of crc-16, msb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    task automatic clear_frame();
        byte_pos = 0;
        first_fault = ST_OK;
        length_field = '0;
        ctrl_byte = '0;
        crc_run = CRC_INIT;
        sum_run = '0;
        check_bytes = '0;
    endtask

    // keep only the first failing header check
    task automatic note_fault(input status_t code);
        if (first_fault == ST_OK)
            first_fault = code;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // work out what one accepted input beat should produce
    task automatic predict_beat(input logic [1:0] cmd, input logic [7:0] b, input logic fin);
        int pos, len, trail;
        logic counted, use_crc;
        status_t verdict;
        logic [7:0] neg_sum;
        frame_result_t item;
        if (cmd == CMD_ADVANCE) begin
            // minus one goes to 0, then 0..3, and 3 wraps to 1
            if (seq_count == SEQ_RESET_VALUE)
                seq_count = 3'd0;
            else if (seq_count < 3'd3)
                seq_count = seq_count + 3'd1;
            else
                seq_count = 3'd1;
            return;
        end
        if (cmd == CMD_SEQ_RESET) begin
            seq_count = SEQ_RESET_VALUE;
            return;
        end
        if (cmd != CMD_BYTE)
            return;

        pos = byte_pos;
        counted = pos < MAX_FRAME;
        if (counted)
            byte_pos = pos + 1;

        // header checks
        case (pos)
            HDR_MARK:    if (b != MARK_BYTE) note_fault(ST_MARK);
            HDR_START:   if (b != START_BYTE) note_fault(ST_START);
            HDR_ADDRESS: if (b != own_address) note_fault(ST_ADDRESS);
            HDR_LEN_LO:  length_field = {8'h00, b};
            HDR_LEN_HI:  length_field[15:8] = b;
            HDR_CTRL:
            begin
                ctrl_byte = b;
                if (!skip_seq && (b & SEQ_MASK) != ({5'b0, seq_count} & SEQ_MASK))
                    note_fault(ST_SEQUENCE);
            end
            default: ;
        endcase

        len = int'(length_field);
        use_crc = (ctrl_byte & CRC_FLAG) != 8'h00;
        trail = use_crc ? 2 : 1;

        // running crc and sum cover the header after the mark and the message block
        if (counted && pos >= HDR_START && (pos <= HDR_CTRL || pos + trail <= len)) begin
            crc_run = crc16_update(crc_run, b);
            sum_run = sum_run + b;
        end
        if (counted && pos >= PAYLOAD_POS)
            check_bytes = {b, check_bytes[15:8]};

        if (!fin) begin
            if (counted && pos >= PAYLOAD_POS && pos + trail <= len) begin
                item.is_status = 1'b0;
                item.payload_byte = b;
                item.status = ST_OK;
                item.payload_length = '0;
                expected_results.push_back(item);
            end
            return;
        end

        // last byte: first failing check decides the status
        verdict = ST_OK;
        neg_sum = 8'h00 - sum_run;
        if (first_fault != ST_OK && first_fault < ST_LENGTH)
            verdict = first_fault;
        else if (pos < HDR_CTRL || len < PAYLOAD_POS + trail || len > MAX_FRAME - 1 || pos != len)
            verdict = ST_LENGTH;
        else if (first_fault != ST_OK)
            verdict = first_fault;
        else if (use_crc) begin
            if (crc_run != check_bytes)
                verdict = ST_CRC;
        end
        else if (neg_sum != check_bytes[15:8])
            verdict = ST_CHECKSUM;

        item.is_status = 1'b1;
        item.payload_byte = '0;
        item.status = verdict;
        item.payload_length = (verdict == ST_OK) ? 10'(len - HDR_CTRL - trail) : 10'd0;
        expected_results.push_back(item);
        clear_frame();
    endtask

    // watch the three channels
    always @(posedge clk)
    begin
        frame_result_t want;
        if (!rst_n) begin
            own_address = '0;
            skip_seq = 1'b0;
            seq_count = SEQ_RESET_VALUE;
            clear_frame();
            expected_results.delete();
            mismatch_count = 0;
            pending_results <= 0;
        end
        else begin
            // result beat against the oldest expectation
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0)
                    report_mismatch("result beat with nothing expected, is_status", is_status, 0);
                else begin
                    want = expected_results.pop_front();
                    if (is_status !== want.is_status)
                        report_mismatch("is_status", is_status, want.is_status);
                    if (payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", payload_byte, want.payload_byte);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (payload_length !== want.payload_length)
                        report_mismatch("payload_length", payload_length, want.payload_length);
                end
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_DEVICE_ADDRESS)
                    own_address = cfg_data;
                else
                    skip_seq = cfg_data[0];
            end
            // input beat
            if (in_valid && in_ready)
                predict_beat(command, rx_byte, last_byte);
            pending_results <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb_access_panel_frame_checker.sv =====
// testbench top for the access panel frame checker: stimulus, idling and verdict
module tb_access_panel_frame_checker;
    timeunit 1ns;
    timeprecision 1ps;
    import apfc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS    = 1450;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = CFG_DEVICE_ADDRESS;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] command = CMD_BYTE;
    logic [7:0] rx_byte = '0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       is_status;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [9:0] payload_length;

    int mismatch_count;
    int pending_results;

    // stimulus knobs and mirrors
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         items_sent = 0;
    int         hold_asked = 0;
    int         hold_done = 0;
    int         hold_left = 0;
    int         idle_cycles = 0;
    logic [2:0] seq_mirror = SEQ_RESET_VALUE;
    logic [7:0] addr_mirror = '0;
    logic [7:0] frame_q[$];
    logic [7:0] payload_src[$];

    access_panel_frame_checker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .rx_byte        (rx_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .is_status      (is_status),
        .payload_byte   (payload_byte),
        .status         (status),
        .payload_length (payload_length)
    );

    apfc_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .rx_byte         (rx_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_status       (is_status),
        .payload_byte    (payload_byte),
        .status          (status),
        .payload_length  (payload_length),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_done != hold_asked) begin
            out_ready <= 1'b0;
            hold_done <= hold_asked;
            hold_left <= HOLD_CYCLES;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // crc-16 bit by bit, msb first
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb = crc[15] ^ b[k];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        rx_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd == CMD_ADVANCE)
            seq_mirror = (seq_mirror == SEQ_RESET_VALUE) ? 3'd0 :
                         (seq_mirror < 3'd3) ? seq_mirror + 3'd1 : 3'd1;
        else if (cmd == CMD_SEQ_RESET)
            seq_mirror = SEQ_RESET_VALUE;
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_DEVICE_ADDRESS)
            addr_mirror = val;
    endtask

    // drop valid and wait until every expected beat has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // well-formed frame for the current address and sequence number
    task automatic build_frame(input int plen, input logic use_crc);
        logic [15:0] len_field, crc;
        logic [7:0]  sum, ctrl;
        len_field = 16'(PAYLOAD_POS + plen + (use_crc ? 2 : 1) - 1);
        ctrl = (8'($urandom_range(255)) & ~(CRC_FLAG | SEQ_MASK))
             | (use_crc ? CRC_FLAG : 8'h00) | {6'b0, seq_mirror[1:0]};
        frame_q.delete();
        frame_q.push_back(MARK_BYTE);
        frame_q.push_back(START_BYTE);
        frame_q.push_back(addr_mirror);
        frame_q.push_back(len_field[7:0]);
        frame_q.push_back(len_field[15:8]);
        frame_q.push_back(ctrl);
        for (int i = 0; i < plen; i++)
            frame_q.push_back(i < payload_src.size() ? payload_src[i] : 8'($urandom_range(255)));
        crc = CRC_INIT;
        sum = '0;
        for (int i = HDR_START; i < frame_q.size(); i++) begin
            crc = crc_next(crc, frame_q[i]);
            sum = sum + frame_q[i];
        end
        if (use_crc) begin
            frame_q.push_back(crc[7:0]);
            frame_q.push_back(crc[15:8]);
        end
        else
            frame_q.push_back(8'h00 - sum);
    endtask

    task automatic trim_frame(input int keep);
        while (frame_q.size() > keep)
            void'(frame_q.pop_back());
    endtask

    // send the frame, with an optional sequence advance slipped in before one byte
    task automatic send_frame(input int cmd_at);
        for (int i = 0; i < frame_q.size(); i++) begin
            if (i == cmd_at)
                send_beat(CMD_ADVANCE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            send_beat(CMD_BYTE, frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    // break a frame in one of several ways, most frames left intact
    task automatic damage_frame();
        int pick, pos;
        pick = $urandom_range(99);
        pos = $urandom_range(0, frame_q.size() - 1);
        if (pick < 65)
            return;
        if (pick < 70)
            frame_q[pos] ^= 8'(1 << $urandom_range(7));
        else if (pick < 75)
            frame_q[$urandom_range(HDR_ADDRESS)] ^= 8'($urandom_range(1, 255));
        else if (pick < 79)
            frame_q[$urandom_range(HDR_LEN_LO, HDR_LEN_HI)] ^= 8'($urandom_range(1, 255));
        else if (pick < 84)
            trim_frame($urandom_range(1, frame_q.size() - 1));
        else if (pick < 88)
            repeat ($urandom_range(1, 4))
                frame_q.insert($urandom_range(PAYLOAD_POS, frame_q.size() - 1),
                               8'($urandom_range(255)));
        else if (pick < 92)
            frame_q[HDR_CTRL] ^= 8'($urandom_range(1, 3));
        else if (pick < 96)
            frame_q[frame_q.size() - 1] ^= 8'($urandom_range(1, 255));
        else begin
            // length field too short for header and trailer
            frame_q[HDR_LEN_LO] = 8'($urandom_range(0, 6));
            frame_q[HDR_LEN_HI] = 8'h00;
        end
    endtask

    task automatic random_step();
        int pick, plen, n;
        if ($urandom_range(99) < 6)
            send_beat($urandom_range(3) == 0 ? CMD_SEQ_RESET : CMD_ADVANCE,
                      8'($urandom_range(255)), 1'($urandom_range(1)));
        else if ($urandom_range(99) < 4) begin
            // stray bytes closed by a last byte
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_beat(CMD_BYTE, 8'($urandom_range(255)), i == n - 1);
        end
        else begin
            pick = $urandom_range(99);
            plen = (pick < 85) ? $urandom_range(0, 12) : $urandom_range(13, 60);
            build_frame(plen, 1'($urandom_range(1)));
            damage_frame();
            send_frame($urandom_range(99) < 4 ? $urandom_range(0, frame_q.size() - 1) : -1);
        end
    endtask

    task automatic directed_frames();
        // good checksum frame, sequence reads 3 after reset
        build_frame(0, 1'b0);
        send_frame(-1);
        // crc frame with extreme payload bytes
        payload_src = '{8'h00, 8'hFF, 8'hA5};
        build_frame(3, 1'b1);
        payload_src.delete();
        send_frame(-1);
        // sequence walks 0,1,2,3 then wraps to 1
        repeat (5) send_beat(CMD_ADVANCE, 8'hFF, 1'b1);
        build_frame(1, 1'b0);
        send_frame(-1);
        send_beat(CMD_SEQ_RESET, 8'h00, 1'b0);
        send_beat(CMD_UNUSED, 8'h5A, 1'b1);
        // mark, start and address errors
        build_frame(2, 1'b0);
        frame_q[HDR_MARK] = 8'h00;
        send_frame(-1);
        build_frame(2, 1'b1);
        frame_q[HDR_START] ^= 8'h01;
        send_frame(-1);
        build_frame(2, 1'b0);
        frame_q[HDR_ADDRESS] = ~addr_mirror;
        send_frame(-1);
        // length field not matching the byte count, and high length byte set
        build_frame(2, 1'b1);
        frame_q[HDR_LEN_LO] ^= 8'h01;
        send_frame(-1);
        build_frame(0, 1'b0);
        frame_q[HDR_LEN_HI] = 8'hFF;
        send_frame(-1);
        // length field too short for the crc trailer
        build_frame(0, 1'b1);
        frame_q[HDR_LEN_LO] = 8'h05;
        send_frame(-1);
        // wrong sequence number
        build_frame(2, 1'b0);
        frame_q[HDR_CTRL] ^= 8'h01;
        send_frame(-1);
        // bad crc, bad checksum
        build_frame(4, 1'b1);
        frame_q[frame_q.size() - 1] ^= 8'h80;
        send_frame(-1);
        build_frame(4, 1'b0);
        frame_q[frame_q.size() - 1] ^= 8'h01;
        send_frame(-1);
        // frame ending inside the header, with and without an earlier header error
        build_frame(0, 1'b0);
        trim_frame(HDR_LEN_LO);
        send_frame(-1);
        build_frame(0, 1'b0);
        frame_q[HDR_ADDRESS] = ~addr_mirror;
        trim_frame(HDR_LEN_HI);
        send_frame(-1);
        // last byte lands in the message block
        build_frame(6, 1'b1);
        trim_frame(PAYLOAD_POS + 3);
        send_frame(-1);
        // sequence advance in the middle of a frame
        build_frame(4, 1'b0);
        send_frame(PAYLOAD_POS + 2);
    endtask

    initial
    begin
        int goal;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(CFG_DEVICE_ADDRESS, 8'h00);
        write_reg(CFG_SKIP_SEQ_CHECK, 8'h00);
        directed_frames();

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'hFF);
                    write_reg(CFG_SKIP_SEQ_CHECK, 8'h01);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'($urandom_range(1, 254)));
                    write_reg(CFG_SKIP_SEQ_CHECK, 8'h00);
                    send_idle_pct = 79;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'h00);
                    write_reg(CFG_SKIP_SEQ_CHECK, 8'h01);
                    send_idle_pct = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'($urandom_range(255)));
                    write_reg(CFG_SKIP_SEQ_CHECK, 8'h00);
                    send_idle_pct = 19;
                    recv_stall_pct = 19;
                end
            endcase
            if (ph == 0) begin
                // largest legal frame, then a frame past the frame limit
                build_frame(MAX_FRAME_DEFAULT - PAYLOAD_POS - 2, 1'b1);
                send_frame(-1);
                build_frame(MAX_FRAME_DEFAULT + 8, 1'b0);
                send_frame(-1);
                // receiver holds off while the sender keeps offering
                hold_asked <= hold_asked + 1;
                build_frame(40, 1'b0);
                send_frame(-1);
            end
            // spread what is left of the item budget over the remaining phases
            goal = items_sent + (TOTAL_ITEMS - items_sent) / (4 - ph);
            while (items_sent < goal)
                random_step();
        end

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/apfc_pkg.sv
rtl/apfc_front.sv
rtl/apfc_queue.sv
rtl/apfc_back.sv
rtl/access_panel_frame_checker.sv
tb/apfc_result_checker.sv
tb/tb_access_panel_frame_checker.sv
